### sv/tbsc_pkg.sv
// ----------------------------------------------------------------------------
// tbsc_pkg
// Shared types and constants for the three-axis boxcar strip chart block:
// register map, configuration record, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tbsc_pkg;

   // Fixed field widths
   localparam int TS_BITS       = 32;
   localparam int WLEN_BITS     = 7;
   localparam int STEP_BITS     = 16;
   localparam int RANGE_BITS    = 16;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int REG_SEL_LSB   = 2;
   localparam int NUM_AXES      = 3;

   // Register reset values
   localparam logic [WLEN_BITS-1:0]         WLEN_RESET  = 7'd1;
   localparam logic [STEP_BITS-1:0]         STEP_RESET  = 16'd1;
   localparam logic signed [RANGE_BITS-1:0] FLOOR_RESET = 16'shB000;   // -5 g
   localparam logic signed [RANGE_BITS-1:0] CEIL_RESET  = 16'sh5000;   // +5 g

   // Register indexes
   typedef enum logic [1:0] {
      REG_WINDOW_LENGTH = 2'd0,
      REG_MIN_TIME_STEP = 2'd1,
      REG_RANGE_FLOOR   = 2'd2,
      REG_RANGE_CEILING = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [WLEN_BITS-1:0]         window_length;
      logic [STEP_BITS-1:0]         min_time_step;
      logic signed [RANGE_BITS-1:0] range_floor;
      logic signed [RANGE_BITS-1:0] range_ceiling;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SUM,
      ST_DRAIN,
      ST_DIVM_START,
      ST_DIVM_WAIT,
      ST_SCALE,
      ST_PRODUCT,
      ST_DIVR_START,
      ST_DIVR_WAIT,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
      logic issue;
      logic advance;
      logic divm_start;
      logic scale;
      logic product;
      logic divr_start;
      logic load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic step_ok;
      logic last_issue;
      logic div_busy;
      logic out_free;
   } sts_type;

endpackage

### sv/tbsc_req_if.sv
// ----------------------------------------------------------------------------
// tbsc_req_if
// Sample request channel: timestamp and three acceleration axes.
// ----------------------------------------------------------------------------
interface tbsc_req_if #(
   parameter int SAMPLE_BITS = 16
);
   import tbsc_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [TS_BITS-1:0]            timestamp;
   logic signed [SAMPLE_BITS-1:0] accel_x;
   logic signed [SAMPLE_BITS-1:0] accel_y;
   logic signed [SAMPLE_BITS-1:0] accel_z;

   modport source (output valid, timestamp, accel_x, accel_y, accel_z, input ready);
   modport sink   (input valid, timestamp, accel_x, accel_y, accel_z, output ready);
endinterface

### sv/tbsc_rsp_if.sv
// ----------------------------------------------------------------------------
// tbsc_rsp_if
// Result channel: per-axis averages, plot rows and the plot flag.
// ----------------------------------------------------------------------------
interface tbsc_rsp_if #(
   parameter int SAMPLE_BITS = 16,
   parameter int ROW_BITS    = 6
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] mean_x;
   logic signed [SAMPLE_BITS-1:0] mean_y;
   logic signed [SAMPLE_BITS-1:0] mean_z;
   logic [ROW_BITS-1:0]           row_x;
   logic [ROW_BITS-1:0]           row_y;
   logic [ROW_BITS-1:0]           row_z;
   logic                          plot_valid;

   modport source (output valid, mean_x, mean_y, mean_z, row_x, row_y, row_z, plot_valid,
                   input ready);
   modport sink   (input valid, mean_x, mean_y, mean_z, row_x, row_y, row_z, plot_valid,
                   output ready);
endinterface

### sv/tbsc_ram.sv
// ----------------------------------------------------------------------------
// tbsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbsc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### sv/tbsc_div.sv
// ----------------------------------------------------------------------------
// tbsc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbsc_div #(
   parameter int N = 22,
   parameter int D = 17
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         busy,
   output logic [N-1:0] quotient
);
   localparam int CB = $clog2(N + 1);

   logic [CB-1:0] cnt_ff, cnt_in;
   logic [N-1:0]  quo_ff, quo_in;
   logic [D:0]    rem_ff, rem_in;
   logic [D-1:0]  den_ff, den_in;
   logic [D:0]    shifted;
   logic [D:0]    trial;
   logic          fits;

   // One shift-and-subtract step
   always_comb begin
      shifted = {rem_ff[D-1:0], quo_ff[N-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
   end

   // Load on start, iterate while busy
   always_comb begin
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (start) begin
         cnt_in = CB'(N);
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[N-2:0], fits};
         rem_in = fits ? trial : shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;
endmodule

### sv/tbsc_csr.sv
// ----------------------------------------------------------------------------
// tbsc_csr
// APB-style register file: window length, minimum time step, plot range.
// ----------------------------------------------------------------------------
module tbsc_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [tbsc_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [tbsc_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [tbsc_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                  pready,
   output tbsc_pkg::cfg_type                     cfg
);
   import tbsc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx    = reg_index_type'(paddr[REG_SEL_LSB +: 2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   // Register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_WINDOW_LENGTH: cfg_in.window_length = pwdata[WLEN_BITS-1:0];
            REG_MIN_TIME_STEP: cfg_in.min_time_step = pwdata[STEP_BITS-1:0];
            REG_RANGE_FLOOR:   cfg_in.range_floor   = pwdata[RANGE_BITS-1:0];
            REG_RANGE_CEILING: cfg_in.range_ceiling = pwdata[RANGE_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length <= WLEN_RESET;
         cfg_ff.min_time_step <= STEP_RESET;
         cfg_ff.range_floor   <= FLOOR_RESET;
         cfg_ff.range_ceiling <= CEIL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read
   always_comb begin
      unique case (idx)
         REG_WINDOW_LENGTH: prdata = CSR_DATA_BITS'(cfg_ff.window_length);
         REG_MIN_TIME_STEP: prdata = CSR_DATA_BITS'(cfg_ff.min_time_step);
         REG_RANGE_FLOOR:   prdata = CSR_DATA_BITS'(cfg_ff.range_floor);
         REG_RANGE_CEILING: prdata = CSR_DATA_BITS'(cfg_ff.range_ceiling);
      endcase
   end

   assign cfg = cfg_ff;
endmodule

### sv/tbsc_ctrl.sv
// ----------------------------------------------------------------------------
// tbsc_ctrl
// Sequencer: gate the request, walk the window, run both divides, hand off
// the result to the output register.
// ----------------------------------------------------------------------------
module tbsc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tbsc_pkg::sts_type sts,
   output tbsc_pkg::cmd_type cmd
);
   import tbsc_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_CHECK;
         ST_CHECK:      state_in = sts.step_ok ? ST_SUM : ST_IDLE;
         ST_SUM:        if (sts.last_issue) state_in = ST_DRAIN;
         ST_DRAIN:      state_in = ST_DIVM_START;
         ST_DIVM_START: state_in = ST_DIVM_WAIT;
         ST_DIVM_WAIT:  if (!sts.div_busy) state_in = ST_SCALE;
         ST_SCALE:      state_in = ST_PRODUCT;
         ST_PRODUCT:    state_in = ST_DIVR_START;
         ST_DIVR_START: state_in = ST_DIVR_WAIT;
         ST_DIVR_WAIT:  if (!sts.div_busy) state_in = ST_FINISH;
         ST_FINISH:     if (sts.out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_CHECK:      cmd.commit     = sts.step_ok;
         ST_SUM:        cmd.issue      = 1'b1;
         ST_DRAIN:      cmd.advance    = 1'b1;
         ST_DIVM_START: cmd.divm_start = 1'b1;
         ST_SCALE:      cmd.scale      = 1'b1;
         ST_PRODUCT:    cmd.product    = 1'b1;
         ST_DIVR_START: cmd.divr_start = 1'b1;
         ST_FINISH:     cmd.load_out   = sts.out_free;
         default:       cmd            = '0;
      endcase
   end
endmodule

### sv/tbsc_dp.sv
// ----------------------------------------------------------------------------
// tbsc_dp
// Datapath: time-step gate, sample ring with valid bits, serial window sum,
// per-axis mean and row divides, output register.
// ----------------------------------------------------------------------------
module tbsc_dp #(
   parameter int  MAX_WINDOW  = 64,
   parameter int  ROWS        = 48,
   parameter int  SAMPLE_BITS = 16,
   localparam int RW          = $clog2(ROWS)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tbsc_pkg::cmd_type                     cmd,
   output tbsc_pkg::sts_type                     sts,
   input  tbsc_pkg::cfg_type                     cfg,
   input  logic [tbsc_pkg::TS_BITS-1:0]          in_timestamp,
   input  logic signed [SAMPLE_BITS-1:0]         in_accel_x,
   input  logic signed [SAMPLE_BITS-1:0]         in_accel_y,
   input  logic signed [SAMPLE_BITS-1:0]         in_accel_z,
   input  logic                                  out_ready,
   output logic                                  out_valid,
   output logic signed [SAMPLE_BITS-1:0]         out_mean_x,
   output logic signed [SAMPLE_BITS-1:0]         out_mean_y,
   output logic signed [SAMPLE_BITS-1:0]         out_mean_z,
   output logic [RW-1:0]                         out_row_x,
   output logic [RW-1:0]                         out_row_y,
   output logic [RW-1:0]                         out_row_z,
   output logic                                  out_plot_valid
);
   import tbsc_pkg::*;

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int WW = $clog2(MAX_WINDOW + 1);
   localparam int CW = $clog2(MAX_WINDOW + 2);
   localparam int SW = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int PW = RANGE_BITS + RW;
   localparam int DN = (SW > PW) ? SW : PW;
   localparam int DD = (WW > RANGE_BITS + 1) ? WW : RANGE_BITS + 1;
   localparam int EW = ((SAMPLE_BITS > RANGE_BITS) ? SAMPLE_BITS : RANGE_BITS) + 1;
   localparam int EB = NUM_AXES * SAMPLE_BITS;

   // Captured request
   logic [TS_BITS-1:0]            ts_ff;
   logic signed [SAMPLE_BITS-1:0] smp_ff [NUM_AXES];

   // Window control
   logic [TS_BITS-1:0]  last_ts_ff, last_ts_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [MAX_WINDOW-1:0] valid_ff, valid_in;
   logic [WW-1:0]       w_ff, w_eff;
   logic [AW-1:0]       k_ff, k_in;
   logic [AW-1:0]       rd_addr;
   logic                rd_pend_ff;
   logic                rd_vld_ff;
   logic [EB-1:0]       ram_rdata;
   logic [TS_BITS-1:0]  ts_delta;

   // Per-lane arithmetic
   logic signed [SW-1:0]          sum_ff  [NUM_AXES];
   logic signed [SAMPLE_BITS-1:0] mean_ff [NUM_AXES];
   logic [PW-1:0]                 prod_ff [NUM_AXES];
   logic                          below_ff [NUM_AXES];
   logic                          high_ff  [NUM_AXES];
   logic [DN-1:0]                 quo     [NUM_AXES];
   logic [NUM_AXES-1:0]           lane_busy;

   // Output register
   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_mean_ff [NUM_AXES];
   logic [RW-1:0]                 out_row_ff  [NUM_AXES];
   logic                          out_plot_ff;

   // Shared range terms
   logic signed [EW-1:0] floor_e, ceil_e, span_e;
   logic [DD-1:0]        span_div;

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ts_ff     <= in_timestamp;
         smp_ff[0] <= in_accel_x;
         smp_ff[1] <= in_accel_y;
         smp_ff[2] <= in_accel_z;
      end
   end

   // Time-step gate, modulo 2^32
   assign ts_delta    = ts_ff - last_ts_ff;
   assign sts.step_ok = ts_delta >= TS_BITS'(cfg.min_time_step);

   // Effective window: zero reads as one, large values saturate
   always_comb begin
      if (cfg.window_length == '0) begin
         w_eff = WW'(1);
      end else if (32'(cfg.window_length) > MAX_WINDOW) begin
         w_eff = WW'(MAX_WINDOW);
      end else begin
         w_eff = WW'(cfg.window_length);
      end
   end

   // Newest-first ring address for the current step
   always_comb begin
      if (ptr_ff >= k_ff) begin
         rd_addr = ptr_ff - k_ff;
      end else begin
         rd_addr = ptr_ff + AW'(MAX_WINDOW) - k_ff;
      end
   end

   assign sts.last_issue = (32'(k_ff) + 32'd1) == 32'(w_ff);

   // Window bookkeeping
   always_comb begin
      last_ts_in = last_ts_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      valid_in   = valid_ff;
      k_in       = k_ff;
      if (cmd.commit) begin
         last_ts_in       = ts_ff;
         valid_in[ptr_ff] = 1'b1;
         k_in             = '0;
         if (32'(count_ff) < MAX_WINDOW + 1) begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.issue) begin
         k_in = k_ff + 1'b1;
      end
      if (cmd.advance) begin
         ptr_in = (ptr_ff == AW'(MAX_WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ts_ff <= '0;
         count_ff   <= '0;
         ptr_ff     <= '0;
         valid_ff   <= '0;
         k_ff       <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         last_ts_ff <= last_ts_in;
         count_ff   <= count_in;
         ptr_ff     <= ptr_in;
         valid_ff   <= valid_in;
         k_ff       <= k_in;
         rd_pend_ff <= cmd.issue;
      end
   end

   // Latch window length and the valid bit beside the ring read
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         w_ff <= w_eff;
      end
      rd_vld_ff <= valid_ff[rd_addr];
   end

   // Sample ring
   tbsc_ram #(
      .WIDTH (EB),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock (clock),
      .we    (cmd.commit),
      .waddr (ptr_ff),
      .wdata ({smp_ff[2], smp_ff[1], smp_ff[0]}),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   // Range terms for the row mapping
   assign floor_e  = EW'(cfg.range_floor);
   assign ceil_e   = EW'(cfg.range_ceiling);
   assign span_e   = ceil_e - floor_e;
   assign span_div = DD'(span_e[RANGE_BITS:0]);

   for (genvar l = 0; l < NUM_AXES; l++) begin : g_lane
      logic signed [SAMPLE_BITS-1:0] rd_smp;
      logic signed [SW-1:0]          sum_in;
      logic [SW-1:0]                 sum_mag;
      logic [DN-1:0]                 div_num;
      logic [DD-1:0]                 div_den;
      logic [SAMPLE_BITS-1:0]        q_low;
      logic signed [EW-1:0]          mean_e;
      logic signed [EW-1:0]          diff_e;
      logic [RANGE_BITS-1:0]         diff_u;
      logic [RW-1:0]                 row_sel;

      assign rd_smp = ram_rdata[l*SAMPLE_BITS +: SAMPLE_BITS];

      // Accumulate; slots never written count as zero
      always_comb begin
         sum_in = sum_ff[l];
         if (cmd.commit) begin
            sum_in = '0;
         end else if (rd_pend_ff && rd_vld_ff) begin
            sum_in = sum_ff[l] + SW'(rd_smp);
         end
      end

      always_ff @(posedge clock) begin
         sum_ff[l] <= sum_in;
      end

      // Divider operands: magnitude of the sum, then the scaled row offset
      assign sum_mag = sum_ff[l][SW-1] ? SW'(-sum_ff[l]) : SW'(sum_ff[l]);
      assign div_num = cmd.divr_start ? DN'(prod_ff[l]) : DN'(sum_mag);
      assign div_den = cmd.divr_start ? span_div : DD'(w_ff);

      tbsc_div #(
         .N (DN),
         .D (DD)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (cmd.divm_start || cmd.divr_start),
         .dividend (div_num),
         .divisor  (div_den),
         .busy     (lane_busy[l]),
         .quotient (quo[l])
      );

      // Restore the sign: truncation toward zero
      assign q_low = quo[l][SAMPLE_BITS-1:0];

      always_ff @(posedge clock) begin
         if (cmd.scale) begin
            mean_ff[l] <= sum_ff[l][SW-1] ? -q_low : q_low;
         end
      end

      // Clamp tests and scaled offset from the floor
      assign mean_e = EW'(mean_ff[l]);
      assign diff_e = mean_e - floor_e;
      assign diff_u = diff_e[RANGE_BITS-1:0];

      always_ff @(posedge clock) begin
         if (cmd.product) begin
            below_ff[l] <= mean_e < floor_e;
            high_ff[l]  <= (span_e <= 0) || (mean_e > ceil_e);
            prod_ff[l]  <= PW'(diff_u) * PW'(ROWS - 1);
         end
      end

      always_comb begin
         if (below_ff[l]) begin
            row_sel = '0;
         end else if (high_ff[l]) begin
            row_sel = RW'(ROWS - 1);
         end else begin
            row_sel = quo[l][RW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.load_out) begin
            out_mean_ff[l] <= mean_ff[l];
            out_row_ff[l]  <= row_sel;
         end
      end
   end

   assign sts.div_busy = |lane_busy;

   // Output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_plot_ff <= 32'(count_ff) > 32'(w_ff);
      end
   end

   assign sts.out_free   = !out_valid_ff || out_ready;
   assign out_valid      = out_valid_ff;
   assign out_mean_x     = out_mean_ff[0];
   assign out_mean_y     = out_mean_ff[1];
   assign out_mean_z     = out_mean_ff[2];
   assign out_row_x      = out_row_ff[0];
   assign out_row_y      = out_row_ff[1];
   assign out_row_z      = out_row_ff[2];
   assign out_plot_valid = out_plot_ff;
endmodule

### sv/triaxial_boxcar_strip_chart_top.sv
// ----------------------------------------------------------------------------
// triaxial_boxcar_strip_chart_top
// Three-axis boxcar average with plot-row mapping.
// ----------------------------------------------------------------------------
// A request whose timestamp has not advanced by min_time_step since the last
// accepted one is dropped with no response. An accepted request is summed
// over the effective window length w (1 to MAX_WINDOW) and then divided for
// the mean and the plot row, with divider width N = max(SAMPLE_BITS +
// log2(MAX_WINDOW), 16 + log2(ROWS)), before the next request is taken. The
// window is summed from the sample RAM one entry a cycle over its single read
// port, and the mean and the plot row each come from a serial divider that
// retires one quotient bit a cycle. The response waits in an output register,
// so a new request is taken while an earlier response is still held. The ring
// needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module triaxial_boxcar_strip_chart_top #(
   parameter int MAX_WINDOW  = 64,
   parameter int ROWS        = 48,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   tbsc_req_if.sink                            req_bus,
   tbsc_rsp_if.source                          rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tbsc_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [tbsc_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [tbsc_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);
   import tbsc_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   // Configuration registers
   tbsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer
   tbsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath
   tbsc_dp #(
      .MAX_WINDOW  (MAX_WINDOW),
      .ROWS        (ROWS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .cfg            (cfg),
      .in_timestamp   (req_bus.timestamp),
      .in_accel_x     (req_bus.accel_x),
      .in_accel_y     (req_bus.accel_y),
      .in_accel_z     (req_bus.accel_z),
      .out_ready      (rsp_bus.ready),
      .out_valid      (rsp_bus.valid),
      .out_mean_x     (rsp_bus.mean_x),
      .out_mean_y     (rsp_bus.mean_y),
      .out_mean_z     (rsp_bus.mean_z),
      .out_row_x      (rsp_bus.row_x),
      .out_row_y      (rsp_bus.row_y),
      .out_row_z      (rsp_bus.row_z),
      .out_plot_valid (rsp_bus.plot_valid)
   );
endmodule

### sv/tbsc_checker.sv
// ----------------------------------------------------------------------------
// tbsc_checker
// Port-level checks for the boxcar strip chart block, bound to the top level.
// ----------------------------------------------------------------------------
module tbsc_checker #(
   parameter int ROWS        = 48,
   parameter int SAMPLE_BITS = 16,
   parameter int ROW_BITS    = 6
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_mean_x,
   input logic [ROW_BITS-1:0]    rsp_row_x,
   input logic [ROW_BITS-1:0]    rsp_row_y,
   input logic [ROW_BITS-1:0]    rsp_row_z
);
   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A taken request keeps the block busy for the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken back to back");

   // A response never appears right after the request that caused it
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response one cycle after request");

   // Plot rows stay on the chart
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row_x <= ROW_BITS'(ROWS - 1)) && (rsp_row_y <= ROW_BITS'(ROWS - 1))
                    && (rsp_row_z <= ROW_BITS'(ROWS - 1)))
      else $error("plot row out of range");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_mean_x))
      else $error("stalled response changed");
endmodule

bind triaxial_boxcar_strip_chart_top tbsc_checker #(
   .ROWS        (ROWS),
   .SAMPLE_BITS (SAMPLE_BITS),
   .ROW_BITS    ($clog2(ROWS))
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_mean_x (rsp_bus.mean_x),
   .rsp_row_x  (rsp_bus.row_x),
   .rsp_row_y  (rsp_bus.row_y),
   .rsp_row_z  (rsp_bus.row_z)
);

### tb/sv/triaxial_boxcar_strip_chart_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triaxial_boxcar_strip_chart_checker
// Watches the register port and both channels of the strip chart block. It
// keeps its own copy of the sample ring and registers, works out the
// averages, plot rows and plot flag of every request that passes the time
// step filter, and compares each response with the oldest one outstanding.
// ----------------------------------------------------------------------------
module triaxial_boxcar_strip_chart_checker #(
   parameter int MAX_WINDOW  = 64,
   parameter int ROWS        = 48,
   parameter int SAMPLE_BITS = 16,
   parameter int ROW_BITS    = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   tbsc_req_if                                req_bus,
   tbsc_rsp_if                                rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic                               pready,
   input  logic [tbsc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [tbsc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output int                                 mismatches,
   output int                                 outstanding,
   output int                                 checked
);
   import tbsc_pkg::*;

   // One predicted response
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] mean_x;
      logic signed [SAMPLE_BITS-1:0] mean_y;
      logic signed [SAMPLE_BITS-1:0] mean_z;
      logic [ROW_BITS-1:0]           row_x;
      logic [ROW_BITS-1:0]           row_y;
      logic [ROW_BITS-1:0]           row_z;
      logic                          plot_valid;
   } chart_point_type;

   localparam int REPORT_LIMIT = 40;

   cfg_type                       regs;
   logic signed [SAMPLE_BITS-1:0] ring_x [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] ring_y [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] ring_z [MAX_WINDOW];
   int                            head;
   logic [TS_BITS-1:0]            last_time;
   int                            seen_count;
   chart_point_type               expected_points [$];

   // Map one average onto a plot row, floor truncated and clamped
   function automatic logic [ROW_BITS-1:0] row_for(input int mean);
      longint lo;
      longint hi;
      lo = $signed(regs.range_floor);
      hi = $signed(regs.range_ceiling);
      if (mean < lo) return '0;
      if (hi - lo <= 0 || mean > hi) return ROW_BITS'(ROWS - 1);
      return ROW_BITS'(((longint'(mean) - lo) * (ROWS - 1)) / (hi - lo));
   endfunction

   // Filter on time step, store the sample and predict its averages
   task automatic average_sample(input logic [TS_BITS-1:0] ts,
                                 input logic signed [SAMPLE_BITS-1:0] ax,
                                 input logic signed [SAMPLE_BITS-1:0] ay,
                                 input logic signed [SAMPLE_BITS-1:0] az);
      logic [TS_BITS-1:0] advance;
      int                 w;
      int                 slot;
      int                 tot_x;
      int                 tot_y;
      int                 tot_z;
      chart_point_type    point;
      advance = ts - last_time;
      if (advance < regs.min_time_step) return;
      last_time = ts;
      if (seen_count < MAX_WINDOW + 1) seen_count++;
      ring_x[head] = ax;
      ring_y[head] = ay;
      ring_z[head] = az;
      w = regs.window_length;
      if (w == 0) w = 1;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      tot_x = 0;
      tot_y = 0;
      tot_z = 0;
      for (int k = 0; k < w; k++) begin
         slot = (head + MAX_WINDOW - k) % MAX_WINDOW;
         tot_x += ring_x[slot];
         tot_y += ring_y[slot];
         tot_z += ring_z[slot];
      end
      head = (head + 1) % MAX_WINDOW;
      point.mean_x     = SAMPLE_BITS'(tot_x / w);
      point.mean_y     = SAMPLE_BITS'(tot_y / w);
      point.mean_z     = SAMPLE_BITS'(tot_z / w);
      point.row_x      = row_for(tot_x / w);
      point.row_y      = row_for(tot_y / w);
      point.row_z      = row_for(tot_z / w);
      point.plot_valid = (seen_count > w);
      expected_points.push_back(point);
   endtask

   task automatic check_field(input string field, input int want_v, input int got_v);
      if (want_v != got_v) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field, want_v, got_v);
      end
   endtask

   // Track register writes, requests and responses on every edge
   always @(posedge clock) begin : watch
      chart_point_type want;
      if (reset) begin
         regs.window_length = WLEN_RESET;
         regs.min_time_step = STEP_RESET;
         regs.range_floor   = FLOOR_RESET;
         regs.range_ceiling = CEIL_RESET;
         for (int i = 0; i < MAX_WINDOW; i++) begin
            ring_x[i] = '0;
            ring_y[i] = '0;
            ring_z[i] = '0;
         end
         head       = 0;
         last_time  = '0;
         seen_count = 0;
         expected_points.delete();
      end else begin
         // Mirror register writes
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[REG_SEL_LSB +: 2]))
               REG_WINDOW_LENGTH: regs.window_length = pwdata[WLEN_BITS-1:0];
               REG_MIN_TIME_STEP: regs.min_time_step = pwdata[STEP_BITS-1:0];
               REG_RANGE_FLOOR:   regs.range_floor   = pwdata[RANGE_BITS-1:0];
               REG_RANGE_CEILING: regs.range_ceiling = pwdata[RANGE_BITS-1:0];
               default: ;
            endcase
         end
         // Predict on each accepted request
         if (req_bus.valid && req_bus.ready)
            average_sample(req_bus.timestamp, req_bus.accel_x, req_bus.accel_y,
                           req_bus.accel_z);
         // Compare each accepted response with the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected response: expected nothing, actual %0d %0d %0d",
                           $time, rsp_bus.mean_x, rsp_bus.mean_y, rsp_bus.mean_z);
            end else begin
               want = expected_points.pop_front();
               checked++;
               check_field("mean_x", want.mean_x, rsp_bus.mean_x);
               check_field("mean_y", want.mean_y, rsp_bus.mean_y);
               check_field("mean_z", want.mean_z, rsp_bus.mean_z);
               check_field("row_x", want.row_x, rsp_bus.row_x);
               check_field("row_y", want.row_y, rsp_bus.row_y);
               check_field("row_z", want.row_z, rsp_bus.row_z);
               check_field("plot_valid", want.plot_valid, rsp_bus.plot_valid);
            end
         end
      end
      outstanding <= expected_points.size();
   end

endmodule

### tb/sv/triaxial_boxcar_strip_chart_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triaxial_boxcar_strip_chart_top_test
// Drives the strip chart block with timestamped three-axis samples: a short
// directed opening on the edge cases of the time filter, window length and
// plot range, then random phases, each with fresh register values, bursty
// requests and a stalling response side. The checker beside the block does
// all prediction and comparison; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module triaxial_boxcar_strip_chart_top_test;
   import tbsc_pkg::*;

   localparam int          SAMPLE_BITS  = 16;
   localparam int          SAMPLE_COUNT = 2000;
   // Leave margin past the longest busy stretch
   localparam int          TAIL_CYCLES  = 200;
   // Upper bound on the run, with a wide margin over a normal run
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   int                       mismatches;
   int                       outstanding;
   int                       checked;
   int unsigned              cycle_count = 0;

   // Stimulus-side view of the time filter, used to shape timestamps
   logic [TS_BITS-1:0]       last_taken;
   logic [STEP_BITS-1:0]     step_now;
   int                       sent;
   int                       taken;
   int                       settings;

   tbsc_req_if req_bus ();
   tbsc_rsp_if rsp_bus ();

   triaxial_boxcar_strip_chart_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   triaxial_boxcar_strip_chart_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Stall the response side in modes chosen at random
   initial begin : drain_pattern
      int mode;
      int left;
      rsp_bus.ready <= 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(50, 400);
         end
         left--;
         case (mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
            2:       rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_bus.ready <= ((left % 24) < 4);
         endcase
      end
   end

   function automatic int rand_q312();
      int unsigned raw;
      raw = $urandom_range(0, 65535);
      return int'(raw) - 32768;
   endfunction

   // Mostly near a level, sometimes full scale or arbitrary
   function automatic int pick_accel(input int level);
      int noise;
      noise = $urandom_range(0, 1023);
      case ($urandom_range(0, 9))
         0:       return -32768;
         1:       return 32767;
         2, 3:    return rand_q312();
         default: return level + noise - 512;
      endcase
   endfunction

   // Mostly a legal advance, some too soon, a few arbitrary jumps
   function automatic logic [TS_BITS-1:0] next_stamp();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return $urandom;
      if (roll < 3) return last_taken + $urandom_range(0, step_now);
      return last_taken + step_now + $urandom_range(0, 40);
   endfunction

   // Offer one request and hold it until accepted
   task automatic send_sample(input logic [TS_BITS-1:0] ts, input int ax, input int ay,
                              input int az);
      req_bus.valid     <= 1'b1;
      req_bus.timestamp <= ts;
      req_bus.accel_x   <= SAMPLE_BITS'(ax);
      req_bus.accel_y   <= SAMPLE_BITS'(ay);
      req_bus.accel_z   <= SAMPLE_BITS'(az);
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
      if (ts - last_taken >= step_now) begin
         last_taken = ts;
         taken++;
      end
   endtask

   // Drop valid and wait until every prediction has been answered
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back
   task automatic apply_settings(input int wlen, input int step, input int lo, input int hi);
      reg_index_type            idx;
      logic [CSR_DATA_BITS-1:0] value;
      idx = idx.first();
      pwrite <= 1'b1;
      repeat (idx.num()) begin
         case (idx)
            REG_WINDOW_LENGTH: value = wlen;
            REG_MIN_TIME_STEP: value = step;
            REG_RANGE_FLOOR:   value = lo;
            default:           value = hi;
         endcase
         psel    <= 1'b1;
         penable <= 1'b0;
         paddr   <= CSR_ADDR_BITS'(idx) << REG_SEL_LSB;
         pwdata  <= value;
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         idx = idx.next();
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      step_now = STEP_BITS'(step);
      settings++;
   endtask

   initial begin : stimulus
      int wlen;
      int step;
      int lo;
      int hi;
      int level [3];
      int quota;
      int phase_end;
      int burst;
      int gap;
      int goal;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.timestamp <= '0;
      req_bus.accel_x   <= '0;
      req_bus.accel_y   <= '0;
      req_bus.accel_z   <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      last_taken = '0;
      step_now   = STEP_RESET;
      sent       = 0;
      taken      = 0;
      settings   = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: window 1, step 1, range -5 g to +5 g
      send_sample(32'd0, 100, 200, 300);            // no advance from zero: dropped
      send_sample(32'd1, 32767, -32768, 0);
      send_sample(32'd1, 5, 5, 5);                  // same stamp: dropped
      send_sample(32'd2, 20480, -20480, -1);        // exactly on ceiling and floor
      send_sample(32'hFFFF_FFFF, -20481, 20481, 1);
      send_sample(32'd3, 4096, -4096, 12);          // advance across the counter wrap
      settle();
      // Zero time step passes repeated stamps; the window starts on earlier samples
      apply_settings(4, 0, -20480, 20480);
      repeat (4) send_sample(32'd3, -32768, 32767, -32768);
      send_sample(32'd3, 32767, -32768, 32767);
      settle();
      // Zero length acts as one
      apply_settings(0, 1, -20480, 20480);
      send_sample(32'd10, -7, 7, -1);
      send_sample(32'd11, 3, -3, 1);
      settle();
      // Oversized length saturates; ceiling equal to floor
      apply_settings(127, 1, 0, 0);
      send_sample(32'd12, -1, 0, 1);
      send_sample(32'd13, 0, 0, 0);
      settle();
      // Ceiling below floor, widest time step
      apply_settings(64, 65535, 100, -100);
      send_sample(32'd13 + 32'd65535, 99, 100, 101);
      send_sample(32'd13 + 32'd65535 + 32'd65534, 1, 2, 3);   // one tick short: dropped
      send_sample(32'd13 + 32'd131070, -32768, -32768, -32768);
      settle();
      // Full span range
      apply_settings(64, 1, -32768, 32767);
      send_sample(32'd200000, 32767, 32767, 32767);
      send_sample(32'd200001, -32768, 0, 32767);
      settle();

      // Random phases, each with its own register values
      goal = taken + SAMPLE_COUNT;
      while (taken < goal) begin
         case ($urandom_range(0, 11))
            0:       wlen = 1;
            1:       wlen = 64;
            2:       wlen = 0;
            3:       wlen = $urandom_range(65, 127);
            4:       wlen = $urandom_range(9, 63);
            default: wlen = $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 5))
            0:       step = 0;
            1:       step = 1;
            2:       step = 65535;
            3:       step = $urandom_range(0, 65535);
            default: step = $urandom_range(0, 64);
         endcase
         case ($urandom_range(0, 5))
            0: begin
               lo = -20480;
               hi = 20480;
            end
            1: begin
               lo = -32768;
               hi = 32767;
            end
            2: begin
               lo = rand_q312();
               hi = lo;
            end
            3: begin
               lo = $urandom_range(0, 32767);
               hi = int'($urandom_range(0, 32767)) - 32768;
            end
            4: begin
               lo = int'($urandom_range(0, 8191)) - 4096;
               hi = lo + int'($urandom_range(1, 200));
            end
            default: begin
               lo = rand_q312();
               hi = rand_q312();
               if (hi < lo) begin
                  gap = lo;
                  lo  = hi;
                  hi  = gap;
               end
            end
         endcase
         settle();
         apply_settings(wlen, step, lo, hi);
         foreach (level[a]) level[a] = rand_q312();
         quota     = $urandom_range(60, 200);
         phase_end = taken + quota;
         while (taken < phase_end) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
               // Shift an axis level now and then
               if ($urandom_range(0, 49) == 0) level[$urandom_range(0, 2)] = rand_q312();
               send_sample(next_stamp(), pick_accel(level[0]), pick_accel(level[1]),
                           pick_accel(level[2]));
            end
            case ($urandom_range(0, 2))
               0:       gap = 0;
               1:       gap = $urandom_range(1, 8);
               default: gap = $urandom_range(9, 150);
            endcase
            if (gap != 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      settle();
      $display("Sent %0d sample requests, %0d past the time-step filter, over %0d register settings.",
               sent, taken, settings);
      $display("Compared %0d responses against the prediction.", checked);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
